/* rtl/cmpaf_pkg.sv */
// Package for the complementary angle filter.
// Holds item types, register indexes, step codes and the microcode program.
// No dependencies.
package cmpaf_pkg;

    localparam int GAIN_W     = 24;
    localparam int ANGLE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int FRAC_W     = 40;
    localparam int MUL_A_W    = 33;
    localparam int MUL_B_W    = 25;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int INC_MAX    = 32767;
    localparam int INC_MIN    = -32768;
    localparam int SH_RATE    = 13;
    localparam int SH_PROP    = 16;
    localparam int SH_DT_HI   = 32;
    localparam int SH_INTEG   = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DT_GAIN    = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_PROP_GAIN  = 3'd2,
        REG_RATE_GAIN  = 3'd3,
        REG_GYRO_ONLY  = 3'd4
    } reg_idx_t;

    localparam logic [GAIN_W-1:0] DT_GAIN_RST    = 24'd167772;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 24'd167772;
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 24'd335544;
    localparam logic [GAIN_W-1:0] RATE_GAIN_RST  = 24'd6835;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] rate_in;
        logic signed [ANGLE_W-1:0] angle_in;
        logic                      angle_valid;
        logic                      clear;
    } sample_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_estimate;
        logic                      increment_saturated;
    } result_t;

    typedef enum logic [2:0] {
        STEP_IDLE   = 3'd0,
        STEP_DIFF   = 3'd1,
        STEP_RATE   = 3'd2,
        STEP_INTEG  = 3'd3,
        STEP_PROP   = 3'd4,
        STEP_DT_LO  = 3'd5,
        STEP_DT_HI  = 3'd6,
        STEP_FINISH = 3'd7
    } step_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_RATE,
        MUL_INTEG,
        MUL_PROP,
        MUL_DT_LO,
        MUL_DT_HI
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_RATE,
        ACC_PROP,
        ACC_DT_LO,
        ACC_DT_HI
    } acc_sel_t;

    typedef enum logic {
        COND_NONE,
        COND_GYRO
    } cond_t;

    typedef struct packed {
        logic     idle;
        logic     diff;
        mul_sel_t mul_sel;
        acc_sel_t acc_sel;
        logic     integ_upd;
        logic     finish;
        cond_t    cond;
        step_t    target;
    } uword_t;

    function automatic uword_t ucode(input step_t step);
        uword_t w;
        w = '{idle: 1'b0, diff: 1'b0, mul_sel: MUL_NONE, acc_sel: ACC_HOLD,
              integ_upd: 1'b0, finish: 1'b0, cond: COND_NONE, target: STEP_IDLE};
        case (step)
            STEP_IDLE:   w.idle = 1'b1;
            STEP_DIFF:
            begin
                w.diff    = 1'b1;
                w.acc_sel = ACC_CLEAR;
                w.mul_sel = MUL_RATE;
            end
            STEP_RATE:
            begin
                w.acc_sel = ACC_RATE;
                w.mul_sel = MUL_INTEG;
                w.cond    = COND_GYRO;
                w.target  = STEP_FINISH;
            end
            STEP_INTEG:
            begin
                w.integ_upd = 1'b1;
                w.mul_sel   = MUL_PROP;
            end
            STEP_PROP:
            begin
                w.acc_sel = ACC_PROP;
                w.mul_sel = MUL_DT_LO;
            end
            STEP_DT_LO:
            begin
                w.acc_sel = ACC_DT_LO;
                w.mul_sel = MUL_DT_HI;
            end
            STEP_DT_HI:  w.acc_sel = ACC_DT_HI;
            STEP_FINISH: w.finish = 1'b1;
            default:     w.idle = 1'b1;
        endcase
        return w;
    endfunction

endpackage

/* rtl/complementary_angle_filter.sv */
// Complementary angle filter: microcoded sequencer over one multiplier and accumulator.
// Steps: DIFF, RATE, INTEG, PROP, DT_LO, DT_HI, FINISH (gyro-only: DIFF, RATE, FINISH).
// One sample at a time: a new sample is accepted only in the idle step, after the seven
// microcode steps (or the gyro-only ones) on the single 33x25 multiplier; finish holds.
// Reset (async, active low) zeroes estimate and integrator and loads default gains.
// Depends on cmpaf_pkg.
module complementary_angle_filter #(
    parameter int INTEG_WIDTH = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  cmpaf_pkg::sample_t                  sample,
    output logic                                result_valid,
    input  logic                                result_ready,
    output cmpaf_pkg::result_t                  result,
    input  logic                                cfg_we,
    input  logic [cmpaf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cmpaf_pkg::GAIN_W-1:0]        cfg_data
);
    import cmpaf_pkg::*;

    localparam int IW = INTEG_WIDTH;
    localparam int AW = IW + 26;
    localparam int SW = IW + 2;
    localparam int QW = AW - FRAC_W;

    logic [GAIN_W-1:0] dt_gain_reg, integ_gain_reg, prop_gain_reg, rate_gain_reg;
    logic              gyro_only_reg;

    step_t                     step_reg, step_next;
    uword_t                    uw;
    logic signed [ANGLE_W-1:0] est_reg, est_next;
    logic signed [IW-1:0]      integ_reg, integ_next;
    sample_t                   item_reg;
    logic signed [ANGLE_W-1:0] diff_reg;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [AW-1:0]      acc_reg, acc_next;
    result_t                   result_reg, result_next;
    logic                      result_valid_reg, result_valid_next;

    logic                      accept, slot_free;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [AW-1:0]      acc_term;
    logic signed [PROD_W-1:0]  delta;
    logic signed [SW-1:0]      integ_sum;
    logic signed [AW-1:0]      q_floor;
    logic signed [QW-1:0]      q_trunc;
    logic signed [ANGLE_W-1:0] inc;
    logic                      inc_sat;

    assign uw           = ucode(step_reg);
    assign sample_ready = uw.idle;
    assign accept       = sample_valid && uw.idle;
    assign slot_free    = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // step sequencing
    always_comb
    begin
        step_next = step_reg;
        if (uw.idle)
        begin
            if (sample_valid)
                step_next = STEP_DIFF;
        end
        else if (uw.finish)
        begin
            if (slot_free)
                step_next = STEP_IDLE;
        end
        else if (uw.cond == COND_GYRO && gyro_only_reg)
            step_next = uw.target;
        else
            step_next = step_t'(step_reg + 3'd1);
    end

    // multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (uw.mul_sel)
            MUL_RATE:
            begin
                mul_a = MUL_A_W'(item_reg.rate_in);
                mul_b = {1'b0, rate_gain_reg};
            end
            MUL_INTEG:
            begin
                mul_a = MUL_A_W'(diff_reg);
                mul_b = {1'b0, integ_gain_reg};
            end
            MUL_PROP:
            begin
                mul_a = MUL_A_W'(diff_reg);
                mul_b = {1'b0, prop_gain_reg};
            end
            MUL_DT_LO:
            begin
                mul_a = {1'b0, integ_reg[31:0]};
                mul_b = {1'b0, dt_gain_reg};
            end
            MUL_DT_HI:
            begin
                mul_a = MUL_A_W'(integ_reg >>> 32);
                mul_b = {1'b0, dt_gain_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = (uw.mul_sel == MUL_NONE) ? prod_reg : mul_a * mul_b;
    end

    // accumulator
    always_comb
    begin
        acc_term = AW'(prod_reg);
        acc_next = acc_reg;
        case (uw.acc_sel)
            ACC_CLEAR: acc_next = '0;
            ACC_RATE:  acc_next = acc_reg + (acc_term <<< SH_RATE);
            ACC_PROP:
            begin
                if (item_reg.angle_valid)
                    acc_next = acc_reg + (acc_term <<< SH_PROP);
            end
            ACC_DT_LO: acc_next = acc_reg + acc_term;
            ACC_DT_HI: acc_next = acc_reg + (acc_term <<< SH_DT_HI);
            default:   acc_next = acc_reg;
        endcase
    end

    // integrator: truncate toward zero, saturating add
    always_comb
    begin
        delta = (prod_reg >>> SH_INTEG)
              + $signed(PROD_W'(prod_reg[PROD_W-1] && (|prod_reg[SH_INTEG-1:0])));
        integ_sum  = SW'(integ_reg) + SW'(delta);
        integ_next = integ_reg;
        if (accept && sample.clear)
            integ_next = '0;
        else if (uw.integ_upd && item_reg.angle_valid)
        begin
            if (integ_sum[SW-1:IW-1] == '0 || integ_sum[SW-1:IW-1] == '1)
                integ_next = IW'(integ_sum);
            else if (integ_sum[SW-1])
                integ_next = {1'b1, {(IW-1){1'b0}}};
            else
                integ_next = {1'b0, {(IW-1){1'b1}}};
        end
    end

    // increment: truncate toward zero, clip to 16 bits
    always_comb
    begin
        q_floor = acc_reg >>> FRAC_W;
        q_trunc = QW'(q_floor) + QW'(acc_reg[AW-1] && (|acc_reg[FRAC_W-1:0]));
        inc_sat = 1'b0;
        inc     = ANGLE_W'(q_trunc);
        if (q_trunc > QW'(INC_MAX))
        begin
            inc_sat = 1'b1;
            inc     = ANGLE_W'(INC_MAX);
        end
        else if (q_trunc < QW'(INC_MIN))
        begin
            inc_sat = 1'b1;
            inc     = ANGLE_W'(INC_MIN);
        end
    end

    always_comb
    begin
        est_next          = est_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (result_ready)
            result_valid_next = 1'b0;
        if (accept && sample.clear)
            est_next = '0;
        else if (uw.finish && slot_free)
        begin
            est_next                        = est_reg + inc;
            result_next.angle_estimate      = est_reg + inc;
            result_next.increment_saturated = inc_sat;
            result_valid_next               = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_gain_reg      <= DT_GAIN_RST;
            integ_gain_reg   <= INTEG_GAIN_RST;
            prop_gain_reg    <= PROP_GAIN_RST;
            rate_gain_reg    <= RATE_GAIN_RST;
            gyro_only_reg    <= 1'b0;
            step_reg         <= STEP_IDLE;
            est_reg          <= '0;
            integ_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DT_GAIN:    dt_gain_reg    <= cfg_data;
                    REG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                    REG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                    REG_RATE_GAIN:  rate_gain_reg  <= cfg_data;
                    REG_GYRO_ONLY:  gyro_only_reg  <= cfg_data[0];
                    default:        gyro_only_reg  <= gyro_only_reg;
                endcase
            end
            step_reg         <= step_next;
            est_reg          <= est_next;
            integ_reg        <= integ_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= sample;
        if (uw.diff)
            diff_reg <= item_reg.angle_in - est_reg;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    a_gyro_integ_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != STEP_IDLE && gyro_only_reg) |=> $stable(integ_reg))
        else $error("integrator moved in gyro-only mode");

    a_no_angle_integ_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.integ_upd && !item_reg.angle_valid) |=> $stable(integ_reg))
        else $error("integrator moved without a valid angle");

    a_result_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> step_reg == STEP_IDLE)
        else $error("result raised while sequencer still busy");

endmodule

/* test/complementary_angle_filter_tb.sv */
// Self-checking testbench for complementary_angle_filter: a directed table, then
// random samples under several idle and stall patterns, checked against a local predictor.
// Depends on cmpaf_pkg and the complementary_angle_filter RTL.
`timescale 1ns / 1ps

module complementary_angle_filter_tb;

    import cmpaf_pkg::*;

    localparam int INTEG_BITS     = 48;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 12;

    localparam longint INTEG_HI = (64'sd1 <<< (INTEG_BITS - 1)) - 1;
    localparam longint INTEG_LO = -INTEG_HI - 1;
    localparam logic signed [127:0] FRAC_ONE = 128'sd1 <<< FRAC_W;
    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(REG_GYRO_ONLY + 1);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_KNOWN,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        sample_t                item;
        result_t                known;
        logic [CFG_IDX_W-1:0]   idx;
        logic [GAIN_W-1:0]      data;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   sample_valid;
    logic                   sample_ready;
    sample_t                sample;
    logic                   result_valid;
    logic                   result_ready;
    result_t                result;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [GAIN_W-1:0]      cfg_data;

    logic [GAIN_W-1:0]      dt_gain_q;
    logic [GAIN_W-1:0]      integ_gain_q;
    logic [GAIN_W-1:0]      prop_gain_q;
    logic [GAIN_W-1:0]      rate_gain_q;
    logic                   gyro_only_q;
    logic [ANGLE_W-1:0]     est_q;
    longint                 integ_acc;

    result_t                expected_estimates[$];
    plan_row_t              plan[$];
    int                     mismatches;
    int                     idle_cycles;
    int                     tx_idle_pct;
    int                     rx_stall_pct;
    int                     hold_requests;

    complementary_angle_filter #(
        .INTEG_WIDTH(INTEG_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .sample(sample),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic result_t predict_estimate(input sample_t s);
        logic signed [127:0] sum;
        logic signed [127:0] quot;
        logic signed [127:0] wide_gain;
        logic signed [127:0] wide_val;
        logic signed [ANGLE_W-1:0] diff16;
        longint diff;
        longint delta;
        longint next_integ;
        result_t r;
        if (s.clear)
        begin
            est_q = '0;
            integ_acc = 0;
        end
        wide_val = s.rate_in;
        wide_gain = {104'd0, rate_gain_q};
        sum = wide_val * wide_gain * 128'sd8192;
        if (!gyro_only_q)
        begin
            if (s.angle_valid)
            begin
                diff16 = s.angle_in - est_q;
                diff = diff16;
                delta = longint'(integ_gain_q) * diff / 64'sd256;
                next_integ = integ_acc + delta;
                if (next_integ > INTEG_HI)
                    next_integ = INTEG_HI;
                else if (next_integ < INTEG_LO)
                    next_integ = INTEG_LO;
                integ_acc = next_integ;
                wide_gain = {104'd0, prop_gain_q};
                wide_val = diff;
                sum = sum + wide_gain * wide_val * 128'sd65536;
            end
            wide_gain = {104'd0, dt_gain_q};
            wide_val = integ_acc;
            sum = sum + wide_gain * wide_val;
        end
        quot = sum / FRAC_ONE;
        r.increment_saturated = (quot > INC_MAX) || (quot < INC_MIN);
        if (quot > INC_MAX)
            quot = INC_MAX;
        else if (quot < INC_MIN)
            quot = INC_MIN;
        est_q = est_q + quot[ANGLE_W-1:0];
        r.angle_estimate = est_q;
        return r;
    endfunction

    function automatic sample_t make_sample(input logic signed [ANGLE_W-1:0] rate,
                                            input logic signed [ANGLE_W-1:0] angle,
                                            input logic valid, input logic clr);
        sample_t s;
        s.rate_in = rate;
        s.angle_in = angle;
        s.angle_valid = valid;
        s.clear = clr;
        return s;
    endfunction

    function automatic void add_item(input logic signed [ANGLE_W-1:0] rate,
                                     input logic signed [ANGLE_W-1:0] angle,
                                     input logic valid, input logic clr);
        plan_row_t row;
        row.kind = ROW_ITEM;
        row.item = make_sample(rate, angle, valid, clr);
        row.known = '0;
        row.idx = '0;
        row.data = '0;
        plan.push_back(row);
    endfunction

    function automatic void add_known(input logic signed [ANGLE_W-1:0] rate,
                                      input logic signed [ANGLE_W-1:0] angle,
                                      input logic valid, input logic clr,
                                      input logic signed [ANGLE_W-1:0] est,
                                      input logic sat);
        plan_row_t row;
        row.kind = ROW_KNOWN;
        row.item = make_sample(rate, angle, valid, clr);
        row.known.angle_estimate = est;
        row.known.increment_saturated = sat;
        row.idx = '0;
        row.data = '0;
        plan.push_back(row);
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [GAIN_W-1:0] data);
        plan_row_t row;
        row.kind = ROW_WRITE;
        row.item = '0;
        row.known = '0;
        row.idx = idx;
        row.data = data;
        plan.push_back(row);
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        if ($urandom_range(0, 1) == 0)
            s.rate_in = 16'($urandom_range(0, 4000)) - 16'd2000;
        else
            s.rate_in = 16'($urandom);
        s.angle_valid = $urandom_range(0, 99) < 75;
        if ($urandom_range(0, 1) == 0)
            s.angle_in = est_q + 16'($urandom_range(0, 2000)) - 16'd1000;
        else
            s.angle_in = 16'($urandom);
        s.clear = $urandom_range(0, 99) < 3;
        return s;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain(input logic [GAIN_W-1:0] rst_value);
        logic [GAIN_W-1:0] g;
        case ($urandom_range(0, 4))
            0:       g = '0;
            1:       g = GAIN_MAX;
            4:       g = GAIN_W'($urandom);
            default: g = rst_value;
        endcase
        return g;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        case (idx)
            REG_DT_GAIN:    dt_gain_q = data;
            REG_INTEG_GAIN: integ_gain_q = data;
            REG_PROP_GAIN:  prop_gain_q = data;
            REG_RATE_GAIN:  rate_gain_q = data;
            REG_GYRO_ONLY:  gyro_only_q = data[0];
            default:        ;
        endcase
        @(negedge clk);
    endtask

    task automatic push_sample(input sample_t s, input logic use_known, input result_t known);
        result_t predicted;
        cfg_we = 1'b0;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            sample_valid = 1'b0;
            @(negedge clk);
        end
        sample = s;
        sample_valid = 1'b1;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        predicted = predict_estimate(s);
        expected_estimates.push_back(use_known ? known : predicted);
        @(negedge clk);
    endtask

    task automatic drain_results();
        sample_valid = 1'b0;
        cfg_we = 1'b0;
        while (expected_estimates.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int count);
        drain_results();
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        write_reg(REG_DT_GAIN, pick_gain(DT_GAIN_RST));
        write_reg(REG_INTEG_GAIN, pick_gain(INTEG_GAIN_RST));
        write_reg(REG_PROP_GAIN, pick_gain(PROP_GAIN_RST));
        write_reg(REG_RATE_GAIN, pick_gain(RATE_GAIN_RST));
        if ($urandom_range(0, 99) < 20)
            write_reg(REG_GYRO_ONLY, GAIN_W'($urandom) | GAIN_W'(1));
        else
            write_reg(REG_GYRO_ONLY, GAIN_W'($urandom) & ~GAIN_W'(1));
        repeat (count) push_sample(random_sample(), 1'b0, '0);
    endtask

    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready = 1'b0;
            end
            else
                result_ready = $urandom_range(0, 99) >= rx_stall_pct;
        end
    end

    always @(posedge clk)
    begin
        result_t exp_r;
        if ((sample_valid && sample_ready) || (result_valid && result_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (result_valid && result_ready)
        begin
            if (expected_estimates.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %0d sat %0b",
                         $time, result.angle_estimate, result.increment_saturated);
            end
            else
            begin
                exp_r = expected_estimates.pop_front();
                if (result.angle_estimate !== exp_r.angle_estimate)
                begin
                    mismatches++;
                    $display("%0t: angle_estimate expected %0d, actual %0d",
                             $time, exp_r.angle_estimate, result.angle_estimate);
                end
                if (result.increment_saturated !== exp_r.increment_saturated)
                begin
                    mismatches++;
                    $display("%0t: increment_saturated expected %0b, actual %0b",
                             $time, exp_r.increment_saturated, result.increment_saturated);
                end
            end
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_requests = 0;
        dt_gain_q = DT_GAIN_RST;
        integ_gain_q = INTEG_GAIN_RST;
        prop_gain_q = PROP_GAIN_RST;
        rate_gain_q = RATE_GAIN_RST;
        gyro_only_q = 1'b0;
        est_q = '0;
        integ_acc = 0;

        add_known(0, 0, 1'b0, 1'b0, 0, 1'b0);
        add_item(1000, 0, 1'b0, 1'b0);
        add_item(0, 16384, 1'b1, 1'b0);
        add_item(-32768, -32768, 1'b1, 1'b0);
        add_item(32767, 32767, 1'b1, 1'b0);
        add_known(0, 0, 1'b0, 1'b1, 0, 1'b0);
        add_item(500, 12345, 1'b1, 1'b1);
        add_item(-700, -20000, 1'b1, 1'b0);
        add_write(REG_GYRO_ONLY, 24'h000001);
        add_item(32767, 5000, 1'b1, 1'b0);
        add_item(-32768, 0, 1'b1, 1'b1);
        add_write(REG_GYRO_ONLY, 24'hFFFFFE);
        add_write(REG_INTEG_GAIN, '0);
        add_write(REG_PROP_GAIN, GAIN_MAX);
        add_write(REG_RATE_GAIN, GAIN_MAX);
        add_known(32767, 32767, 1'b1, 1'b1, 32767, 1'b1);
        add_known(-32768, -32768, 1'b1, 1'b1, -32768, 1'b1);
        add_write(REG_DT_GAIN, GAIN_MAX);
        add_write(REG_INTEG_GAIN, GAIN_MAX);
        add_write(REG_PROP_GAIN, '0);
        add_write(REG_RATE_GAIN, '0);
        add_item(0, 32767, 1'b1, 1'b1);
        add_item(0, -32768, 1'b1, 1'b0);
        add_item(0, 0, 1'b0, 1'b0);
        add_write(REG_UNUSED_LO, GAIN_MAX);
        add_write(REG_UNUSED_HI, '0);
        add_item(0, 0, 1'b0, 1'b0);
        add_write(REG_DT_GAIN, DT_GAIN_RST);
        add_write(REG_INTEG_GAIN, INTEG_GAIN_RST);
        add_write(REG_PROP_GAIN, PROP_GAIN_RST);
        add_write(REG_RATE_GAIN, RATE_GAIN_RST);
        add_write(REG_GYRO_ONLY, '0);
        add_item(-1, -1, 1'b1, 1'b1);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                if (sample_valid)
                    drain_results();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
                push_sample(plan[i].item, plan[i].kind == ROW_KNOWN, plan[i].known);
        end

        run_phase(0, 0, 100);
        run_phase(72, 0, 100);
        run_phase(0, 72, 100);
        run_phase(37, 37, 100);

        run_phase(0, 0, 0);
        hold_requests++;
        repeat (30) push_sample(random_sample(), 1'b0, '0);

        drain_results();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
